>>> rtl/char_class_dfa_lexer_defines.svh
// ----------------------------------------------------------------------------
// Character-class DFA lexer: assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHAR_CLASS_DFA_LEXER_DEFINES_SVH
`define CHAR_CLASS_DFA_LEXER_DEFINES_SVH

`ifndef SYNTH

// Assert a property on every rising clock edge outside reset
`define CDL_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle
`define CDL_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle
`define CDL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define CDL_ASSERT(name, clk, rstn, prop, msg)
`define CDL_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define CDL_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/cdl_pkg.sv
// ----------------------------------------------------------------------------
// Character-class DFA lexer package
// Token kinds, character classes, lexer states and the queue item format.
// ----------------------------------------------------------------------------
package cdl_pkg;

  localparam int unsigned KindW     = 5;
  localparam int unsigned FieldW    = 16;
  localparam int unsigned CharW     = 8;
  localparam int unsigned QueueDepth = 2;

  typedef logic [KindW-1:0] tok_kind_t;

  localparam tok_kind_t TK_IDENT  = 5'd0;
  localparam tok_kind_t TK_NUM    = 5'd1;
  localparam tok_kind_t TK_ADD    = 5'd2;
  localparam tok_kind_t TK_SUB    = 5'd3;
  localparam tok_kind_t TK_MUL    = 5'd4;
  localparam tok_kind_t TK_DIV    = 5'd5;
  localparam tok_kind_t TK_ASSIGN = 5'd6;
  localparam tok_kind_t TK_EQ     = 5'd7;
  localparam tok_kind_t TK_LT     = 5'd8;
  localparam tok_kind_t TK_LE     = 5'd9;
  localparam tok_kind_t TK_GT     = 5'd10;
  localparam tok_kind_t TK_GE     = 5'd11;
  localparam tok_kind_t TK_NOT    = 5'd12;
  localparam tok_kind_t TK_NE     = 5'd13;
  localparam tok_kind_t TK_COMMA  = 5'd14;
  localparam tok_kind_t TK_SEMI   = 5'd15;
  localparam tok_kind_t TK_LBRACE = 5'd16;
  localparam tok_kind_t TK_RBRACE = 5'd17;
  localparam tok_kind_t TK_LPAREN = 5'd18;
  localparam tok_kind_t TK_RPAREN = 5'd19;
  localparam tok_kind_t TK_EOF    = 5'd20;
  localparam tok_kind_t TK_ERR    = 5'd21;

  typedef enum logic [3:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_SLASH,
    CLS_STAR,
    CLS_EQ,
    CLS_LT,
    CLS_GT,
    CLS_BANG,
    CLS_SINGLE,
    CLS_INVALID
  } char_cls_e;

  typedef enum logic [10:0] {
    ST_START      = 11'b000_0000_0001,
    ST_IDENT      = 11'b000_0000_0010,
    ST_NUM        = 11'b000_0000_0100,
    ST_SLASH      = 11'b000_0000_1000,
    ST_BLOCK      = 11'b000_0001_0000,
    ST_BLOCK_STAR = 11'b000_0010_0000,
    ST_LINE       = 11'b000_0100_0000,
    ST_EQ         = 11'b000_1000_0000,
    ST_LT         = 11'b001_0000_0000,
    ST_GT         = 11'b010_0000_0000,
    ST_BANG       = 11'b100_0000_0000
  } lex_state_e;

  // Classified item as it sits in the queue
  typedef struct packed {
    logic      eoi;
    char_cls_e cls;
    tok_kind_t single_kind;
  } lex_item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    tok_kind_t         kind;
    logic [FieldW-1:0] start;
    logic [FieldW-1:0] len;
  } tok_t;

endpackage

>>> rtl/cdl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accept input items and classify each byte before it enters the queue.
// ----------------------------------------------------------------------------
module cdl_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cdl_pkg::CharW-1:0]  char_i,
  input  logic                       eoi_i,
  input  cdl_pkg::q_status_t         q_status_i,
  output logic                       push_o,
  output cdl_pkg::lex_item_t         item_o
);

  cdl_pkg::char_cls_e cls;
  cdl_pkg::tok_kind_t single_kind;

  always_comb begin
    cls         = cdl_pkg::CLS_INVALID;
    single_kind = cdl_pkg::TK_ERR;
    unique case (char_i) inside
      [8'h41:8'h5A], [8'h61:8'h7A]: cls = cdl_pkg::CLS_LETTER;
      [8'h30:8'h39]:                cls = cdl_pkg::CLS_DIGIT;
      8'h20, 8'h09:                 cls = cdl_pkg::CLS_SPACE;
      8'h0A:                        cls = cdl_pkg::CLS_NEWLINE;
      8'h2F:                        cls = cdl_pkg::CLS_SLASH;
      8'h3D:                        cls = cdl_pkg::CLS_EQ;
      8'h3C:                        cls = cdl_pkg::CLS_LT;
      8'h3E:                        cls = cdl_pkg::CLS_GT;
      8'h21:                        cls = cdl_pkg::CLS_BANG;
      8'h2A: begin
        cls         = cdl_pkg::CLS_STAR;
        single_kind = cdl_pkg::TK_MUL;
      end
      8'h2B: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_ADD;
      end
      8'h2D: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_SUB;
      end
      8'h2C: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_COMMA;
      end
      8'h3B: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_SEMI;
      end
      8'h7B: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_LBRACE;
      end
      8'h7D: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_RBRACE;
      end
      8'h28: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_LPAREN;
      end
      8'h29: begin
        cls         = cdl_pkg::CLS_SINGLE;
        single_kind = cdl_pkg::TK_RPAREN;
      end
      default: begin
        cls         = cdl_pkg::CLS_INVALID;
        single_kind = cdl_pkg::TK_ERR;
      end
    endcase
  end

  assign in_ready_o          = !q_status_i.full;
  assign push_o              = in_valid_i && !q_status_i.full;
  assign item_o.eoi          = eoi_i;
  assign item_o.cls          = cls;
  assign item_o.single_kind  = single_kind;

endmodule

>>> rtl/cdl_queue.sv
// ----------------------------------------------------------------------------
// Lexer item queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module cdl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cdl_pkg::lex_item_t  item_i,
  input  logic                pop_i,
  output cdl_pkg::lex_item_t  item_o,
  output cdl_pkg::q_status_t  status_o
);

  localparam int unsigned PtrW = (cdl_pkg::QueueDepth > 1) ? $clog2(cdl_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(cdl_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(cdl_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(cdl_pkg::QueueDepth);

  cdl_pkg::lex_item_t entries_q [cdl_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign do_push = push_i && (count_q != FullCnt);
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o             = entries_q[rd_ptr_q];
  assign status_o.not_empty = (count_q != '0);
  assign status_o.full      = (count_q == FullCnt);

endmodule

>>> rtl/cdl_back.sv
// ----------------------------------------------------------------------------
// Lexer back end
// Step the lexer state machine on queued items and register each token.
// ----------------------------------------------------------------------------
module cdl_back #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdl_pkg::q_status_t  q_status_i,
  input  cdl_pkg::lex_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdl_pkg::tok_t       out_tok_o,
  output logic                out_last_o
);

  localparam int unsigned LenW = (OFFSET_BITS < cdl_pkg::FieldW) ? OFFSET_BITS : cdl_pkg::FieldW;

  cdl_pkg::lex_state_e      state_q, state_d;
  logic [OFFSET_BITS-1:0]   pos_q, pos_d;
  logic [OFFSET_BITS-1:0]   pstart_q, pstart_d;
  logic [LenW-1:0]          plen_q, plen_d;
  logic                     halted_q, halted_d;
  logic                     phase_q, phase_d;
  logic                     out_valid_q, out_valid_d;
  cdl_pkg::tok_t            out_tok_q;
  logic                     out_last_q;

  logic [31:0]               pos_ext, pstart_ext;
  logic [cdl_pkg::FieldW-1:0] pos16, pstart16, plen16;

  // Outcome of handling the byte from the start state
  cdl_pkg::lex_state_e fs_state;
  logic                fs_begin, fs_emit, fs_err;
  cdl_pkg::tok_t       fs_tok;

  cdl_pkg::tok_t       r0, r1;
  logic [1:0]          n_res;
  logic                use_fs, flushed;
  cdl_pkg::tok_kind_t  one_kind, two_kind;
  logic                adv, load;

  assign pos_ext    = 32'(pos_q);
  assign pstart_ext = 32'(pstart_q);
  assign pos16      = pos_ext[cdl_pkg::FieldW-1:0];
  assign pstart16   = pstart_ext[cdl_pkg::FieldW-1:0];
  assign plen16     = cdl_pkg::FieldW'(plen_q);

  always_comb begin
    fs_state = cdl_pkg::ST_START;
    fs_begin = 1'b0;
    fs_emit  = 1'b0;
    fs_err   = 1'b0;
    fs_tok   = '{kind: item_i.single_kind, start: pos16, len: cdl_pkg::FieldW'(1)};
    unique case (item_i.cls) inside
      cdl_pkg::CLS_LETTER: begin
        fs_state = cdl_pkg::ST_IDENT;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_DIGIT: begin
        fs_state = cdl_pkg::ST_NUM;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_SLASH: begin
        fs_state = cdl_pkg::ST_SLASH;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_EQ: begin
        fs_state = cdl_pkg::ST_EQ;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_LT: begin
        fs_state = cdl_pkg::ST_LT;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_GT: begin
        fs_state = cdl_pkg::ST_GT;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_BANG: begin
        fs_state = cdl_pkg::ST_BANG;
        fs_begin = 1'b1;
      end
      cdl_pkg::CLS_STAR, cdl_pkg::CLS_SINGLE: begin
        fs_emit = 1'b1;
      end
      cdl_pkg::CLS_INVALID: begin
        fs_emit     = 1'b1;
        fs_err      = 1'b1;
        fs_tok.kind = cdl_pkg::TK_ERR;
      end
      default: begin
        fs_state = cdl_pkg::ST_START;
      end
    endcase
  end

  always_comb begin
    one_kind = cdl_pkg::TK_ASSIGN;
    two_kind = cdl_pkg::TK_EQ;
    unique case (state_q)
      cdl_pkg::ST_LT: begin
        one_kind = cdl_pkg::TK_LT;
        two_kind = cdl_pkg::TK_LE;
      end
      cdl_pkg::ST_GT: begin
        one_kind = cdl_pkg::TK_GT;
        two_kind = cdl_pkg::TK_GE;
      end
      cdl_pkg::ST_BANG: begin
        one_kind = cdl_pkg::TK_NOT;
        two_kind = cdl_pkg::TK_NE;
      end
      default: begin
        one_kind = cdl_pkg::TK_ASSIGN;
        two_kind = cdl_pkg::TK_EQ;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    plen_d   = plen_q;
    halted_d = halted_q;
    r0       = '0;
    r1       = '0;
    n_res    = 2'd0;
    use_fs   = 1'b0;
    flushed  = 1'b0;

    if (item_i.eoi) begin
      // Flush any pending token, then end of file; rewind everything
      if (!halted_q) begin
        r0.start = pstart16;
        r0.len   = cdl_pkg::FieldW'(1);
        n_res    = 2'd1;
        unique case (state_q) inside
          cdl_pkg::ST_IDENT: begin
            r0.kind = cdl_pkg::TK_IDENT;
            r0.len  = plen16;
          end
          cdl_pkg::ST_NUM: begin
            r0.kind = cdl_pkg::TK_NUM;
            r0.len  = plen16;
          end
          cdl_pkg::ST_SLASH:                 r0.kind = cdl_pkg::TK_DIV;
          cdl_pkg::ST_EQ, cdl_pkg::ST_LT,
          cdl_pkg::ST_GT, cdl_pkg::ST_BANG:  r0.kind = one_kind;
          default:                           n_res   = 2'd0;
        endcase
      end
      if (n_res == 2'd1) begin
        r1    = '{kind: cdl_pkg::TK_EOF, start: pos16, len: '0};
        n_res = 2'd2;
      end else begin
        r0    = '{kind: cdl_pkg::TK_EOF, start: pos16, len: '0};
        n_res = 2'd1;
      end
      state_d  = cdl_pkg::ST_START;
      pos_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      pos_d = pos_q + 1'b1;
      unique case (state_q) inside
        cdl_pkg::ST_START: begin
          use_fs = 1'b1;
        end
        cdl_pkg::ST_IDENT, cdl_pkg::ST_NUM: begin
          if (item_i.cls == cdl_pkg::CLS_DIGIT ||
              (state_q == cdl_pkg::ST_IDENT && item_i.cls == cdl_pkg::CLS_LETTER)) begin
            if (plen_q != '1) begin
              plen_d = plen_q + 1'b1;
            end
          end else if (item_i.cls == cdl_pkg::CLS_INVALID) begin
            // Drop the pending token and report the bad byte
            r0       = '{kind: cdl_pkg::TK_ERR, start: pos16, len: cdl_pkg::FieldW'(1)};
            n_res    = 2'd1;
            halted_d = 1'b1;
            state_d  = cdl_pkg::ST_START;
            plen_d   = '0;
          end else begin
            r0.kind  = (state_q == cdl_pkg::ST_IDENT) ? cdl_pkg::TK_IDENT : cdl_pkg::TK_NUM;
            r0.start = pstart16;
            r0.len   = plen16;
            n_res    = 2'd1;
            use_fs   = 1'b1;
            flushed  = 1'b1;
          end
        end
        cdl_pkg::ST_SLASH: begin
          if (item_i.cls == cdl_pkg::CLS_STAR) begin
            state_d = cdl_pkg::ST_BLOCK;
            plen_d  = '0;
          end else if (item_i.cls == cdl_pkg::CLS_SLASH) begin
            state_d = cdl_pkg::ST_LINE;
            plen_d  = '0;
          end else begin
            r0      = '{kind: cdl_pkg::TK_DIV, start: pstart16, len: plen16};
            n_res   = 2'd1;
            use_fs  = 1'b1;
            flushed = 1'b1;
          end
        end
        cdl_pkg::ST_BLOCK: begin
          if (item_i.cls == cdl_pkg::CLS_STAR) begin
            state_d = cdl_pkg::ST_BLOCK_STAR;
          end
        end
        cdl_pkg::ST_BLOCK_STAR: begin
          if (item_i.cls == cdl_pkg::CLS_SLASH) begin
            state_d = cdl_pkg::ST_START;
          end else if (item_i.cls != cdl_pkg::CLS_STAR) begin
            state_d = cdl_pkg::ST_BLOCK;
          end
        end
        cdl_pkg::ST_LINE: begin
          if (item_i.cls == cdl_pkg::CLS_NEWLINE) begin
            state_d = cdl_pkg::ST_START;
          end
        end
        cdl_pkg::ST_EQ, cdl_pkg::ST_LT, cdl_pkg::ST_GT, cdl_pkg::ST_BANG: begin
          if (item_i.cls == cdl_pkg::CLS_EQ) begin
            // Join the two-character operator
            r0      = '{kind: two_kind, start: pstart16, len: cdl_pkg::FieldW'(2)};
            n_res   = 2'd1;
            state_d = cdl_pkg::ST_START;
            plen_d  = '0;
          end else begin
            r0      = '{kind: one_kind, start: pstart16, len: plen16};
            n_res   = 2'd1;
            use_fs  = 1'b1;
            flushed = 1'b1;
          end
        end
        default: begin
          use_fs = 1'b1;
        end
      endcase

      if (use_fs) begin
        state_d = fs_state;
        plen_d  = '0;
        if (fs_begin) begin
          pstart_d = pos_q;
          plen_d   = LenW'(1);
        end
        if (fs_emit) begin
          if (flushed) begin
            r1    = fs_tok;
            n_res = 2'd2;
          end else begin
            r0    = fs_tok;
            n_res = 2'd1;
          end
        end
        if (fs_err) begin
          halted_d = 1'b1;
        end
      end
    end
  end

  // An item with two tokens takes two turns; state moves only on the last
  assign adv   = q_status_i.not_empty && (!out_valid_q || out_ready_i);
  assign load  = adv && (n_res != 2'd0);
  assign pop_o = adv && ((n_res != 2'd2) || phase_q);

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (adv && n_res == 2'd2) begin
      phase_d = !phase_q;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdl_pkg::ST_START;
      pos_q       <= '0;
      pstart_q    <= '0;
      plen_q      <= '0;
      halted_q    <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        state_q  <= state_d;
        pos_q    <= pos_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q  <= phase_q ? r1 : r0;
      out_last_q <= phase_q || (n_res == 2'd1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign out_last_o  = out_last_q;

endmodule

>>> rtl/char_class_dfa_lexer.sv
// ----------------------------------------------------------------------------
// Character-class DFA lexer
// Streaming tokeniser: bytes in, one result per token out.
// ----------------------------------------------------------------------------
// Each input item carries one source byte, or an end-of-input marker in
// tuser. Bytes are classified on entry and parked in a two-entry queue; the
// back end steps an eleven-state lexer (start, identifier, number, slash,
// block comment, block comment after star, line comment, '=', '<', '>', '!')
// and emits a token with its kind, start offset and saturating length.
// Whitespace and comments give nothing; '==', '<=', '>=' and '!=' are joined.
// A byte that ends a pending token is then lexed from the start state, so
// one byte can give two results; tlast marks the final result of an item.
// An invalid byte outside a comment gives an error token and halts the
// lexer until the next end of input, which flushes any pending token,
// emits end-of-file and rewinds the offset to zero. Rate: the front end
// takes an item in every cycle while the queue has room. The back end
// retires an item when its last token is loaded into the output register,
// which is loaded once per token and holds while the receiver stalls. An
// item is registered in the queue, its first token in the output register.
// ----------------------------------------------------------------------------
`include "char_class_dfa_lexer_defines.svh"

module char_class_dfa_lexer #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]  s_axis_tuser,   // [0] kind (1 = end of input)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [4:0] token_kind, [20:5] token_start,
                                      // [36:21] token_length, [39:37] zero
  output logic        m_axis_tlast    // last
);

  cdl_pkg::q_status_t q_status;
  cdl_pkg::lex_item_t in_item;
  cdl_pkg::lex_item_t head_item;
  logic               push;
  logic               pop;
  cdl_pkg::tok_t      out_tok;

  logic [cdl_pkg::KindW-1:0]  out_kind;
  logic [cdl_pkg::FieldW-1:0] out_start;
  logic [cdl_pkg::FieldW-1:0] out_len;

  // Classify and accept while the queue has room
  cdl_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .eoi_i      (s_axis_tuser[0]),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (in_item)
  );

  // Decouple the two ends so either may stall on its own
  cdl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  // Lexer state machine and output register
  cdl_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast)
  );

  assign out_kind     = out_tok.kind;
  assign out_start    = out_tok.start;
  assign out_len      = out_tok.len;
  assign m_axis_tdata = {3'b000, out_len, out_start, out_kind};

  // The second token of a pair follows straight after the first is taken
  `CDL_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "second token of a pair missing")

  // End of file closes its item and carries no length
  `CDL_ASSERT_IMPL(a_eof_shape, clk_i, rst_ni, m_axis_tvalid && out_kind == cdl_pkg::TK_EOF, m_axis_tlast && out_len == '0, "malformed end-of-file token")

  // An error token is one byte long and is always the final token of its item
  `CDL_ASSERT_IMPL(a_err_shape, clk_i, rst_ni, m_axis_tvalid && out_kind == cdl_pkg::TK_ERR, m_axis_tlast && out_len == cdl_pkg::FieldW'(1), "malformed error token")

  // Only defined token kinds leave the block
  `CDL_ASSERT_IMPL(a_kind_range, clk_i, rst_ni, m_axis_tvalid, out_kind <= cdl_pkg::TK_ERR, "undefined token kind")

endmodule

>>> tb/char_class_dfa_lexer_test.sv
// ----------------------------------------------------------------------------
// Character-class DFA lexer testbench
// Feeds a short table of directed bytes and about two thousand random lexeme
// bytes, with bursty input and a stalling output side. A behavioural model
// of the lexer predicts each token not typed into the directed table by hand,
// and each token leaving the block is checked against the oldest one due.
// ----------------------------------------------------------------------------
module char_class_dfa_lexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [15:0] LEN_MAX      = 16'hFFFF;
  localparam int          PREDICT      = -1;

  typedef struct packed {
    cdl_pkg::tok_kind_t kind;
    logic [15:0]        start;
    logic [15:0]        len;
    logic               last;
  } token_rec_t;

  // One source item; n_given >= 0 means the tokens below are typed in by hand
  typedef struct {
    logic       eoi;
    logic [7:0] ch;
    int         n_given;
    token_rec_t given0;
    token_rec_t given1;
  } src_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  localparam token_rec_t NO_TOK = '0;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] char_code
  logic [0:0]  s_axis_tuser  = '0;   // [0] kind (1 = end of input)
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // [4:0] kind, [20:5] start, [36:21] length
  logic        m_axis_tlast;

  char_class_dfa_lexer #(
    .OFFSET_BITS(16)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Directed bytes: operators, relop joining, comments with a run of stars,
  // invalid bytes inside and outside comments, the halt and its release.
  src_item_t dir_table [26] = '{
    '{1'b0, "+",   1, '{cdl_pkg::TK_ADD, 16'd0, 16'd1, 1'b1}, NO_TOK},
    '{1'b0, "Z",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "9",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "<",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "=",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "!",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "/",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "*",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "*",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "*",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, 8'h80, PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "*",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "/",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "/",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "/",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "\n",  PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "0",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, ">",   PREDICT, NO_TOK, NO_TOK},
    '{1'b0, 8'h00, PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "q",   PREDICT, NO_TOK, NO_TOK},
    '{1'b1, 8'hFF, PREDICT, NO_TOK, NO_TOK},
    '{1'b1, 8'h00, 1, '{cdl_pkg::TK_EOF, 16'd0, 16'd0, 1'b1}, NO_TOK},
    '{1'b0, 8'hFF, 1, '{cdl_pkg::TK_ERR, 16'd0, 16'd1, 1'b1}, NO_TOK},
    '{1'b1, 8'hA5, PREDICT, NO_TOK, NO_TOK},
    '{1'b0, "=",   PREDICT, NO_TOK, NO_TOK},
    '{1'b1, 8'h5A, PREDICT, NO_TOK, NO_TOK}
  };

  src_item_t  feed_q[$];
  src_item_t  offered;
  token_rec_t step_toks[$];
  token_rec_t tokens_due[$];
  logic       item_taken = 1'b0;
  int         mismatch_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         rx_cycle = 0;
  int         hold_left = 0;
  int         mode_left = 0;
  rx_mode_e   rx_mode = RX_OPEN;

  // Lexer model state
  cdl_pkg::lex_state_e lx_state  = cdl_pkg::ST_START;
  logic [15:0]         lx_pos    = '0;
  logic [15:0]         lx_pstart = '0;
  logic [15:0]         lx_plen   = '0;
  logic                lx_halted = 1'b0;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int punct_kind(logic [7:0] c);
    case (c)
      "+":     return int'(cdl_pkg::TK_ADD);
      "-":     return int'(cdl_pkg::TK_SUB);
      "*":     return int'(cdl_pkg::TK_MUL);
      ",":     return int'(cdl_pkg::TK_COMMA);
      ";":     return int'(cdl_pkg::TK_SEMI);
      "{":     return int'(cdl_pkg::TK_LBRACE);
      "}":     return int'(cdl_pkg::TK_RBRACE);
      "(":     return int'(cdl_pkg::TK_LPAREN);
      ")":     return int'(cdl_pkg::TK_RPAREN);
      default: return -1;
    endcase
  endfunction

  function automatic logic is_valid(logic [7:0] c);
    return is_letter(c) || is_digit(c) || punct_kind(c) >= 0 ||
           (c inside {"/", " ", "\t", "\n", "=", "<", ">", "!"});
  endfunction

  function automatic void lex_emit(cdl_pkg::tok_kind_t kind, logic [15:0] start,
                                   logic [15:0] len);
    step_toks.push_back('{kind, start, len, 1'b0});
  endfunction

  function automatic void lex_error();
    lex_emit(cdl_pkg::TK_ERR, lx_pos, 16'd1);
    lx_halted = 1'b1;
    lx_state  = cdl_pkg::ST_START;
    lx_plen   = '0;
  endfunction

  function automatic void lex_open(cdl_pkg::lex_state_e st);
    lx_state  = st;
    lx_pstart = lx_pos;
    lx_plen   = 16'd1;
  endfunction

  function automatic void lex_from_start(logic [7:0] c);
    int k;
    k = punct_kind(c);
    lx_state = cdl_pkg::ST_START;
    lx_plen  = '0;
    if (c inside {" ", "\t", "\n"}) return;
    if (is_letter(c)) lex_open(cdl_pkg::ST_IDENT);
    else if (is_digit(c)) lex_open(cdl_pkg::ST_NUM);
    else if (c == "/") lex_open(cdl_pkg::ST_SLASH);
    else if (c == "=") lex_open(cdl_pkg::ST_EQ);
    else if (c == "<") lex_open(cdl_pkg::ST_LT);
    else if (c == ">") lex_open(cdl_pkg::ST_GT);
    else if (c == "!") lex_open(cdl_pkg::ST_BANG);
    else if (k >= 0) lex_emit(cdl_pkg::tok_kind_t'(k), lx_pos, 16'd1);
    else lex_error();
  endfunction

  // Emit the pending token, then lex the ending byte afresh
  function automatic void lex_flush_restart(cdl_pkg::tok_kind_t kind, logic [7:0] c);
    lex_emit(kind, lx_pstart, lx_plen);
    lex_from_start(c);
  endfunction

  function automatic void lex_relop(logic [7:0] c, cdl_pkg::tok_kind_t one,
                                    cdl_pkg::tok_kind_t two);
    if (c == "=") begin
      lex_emit(two, lx_pstart, 16'd2);
      lx_state = cdl_pkg::ST_START;
      lx_plen  = '0;
    end else begin
      lex_flush_restart(one, c);
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    case (lx_state) inside
      cdl_pkg::ST_IDENT, cdl_pkg::ST_NUM: begin
        if (is_digit(c) || (lx_state == cdl_pkg::ST_IDENT && is_letter(c))) begin
          if (lx_plen != LEN_MAX) lx_plen++;
        end else if (!is_valid(c)) begin
          lex_error();
        end else begin
          lex_flush_restart(lx_state == cdl_pkg::ST_IDENT ? cdl_pkg::TK_IDENT
                                                          : cdl_pkg::TK_NUM, c);
        end
      end
      cdl_pkg::ST_SLASH: begin
        if (c == "*") begin
          lx_state = cdl_pkg::ST_BLOCK;
          lx_plen  = '0;
        end else if (c == "/") begin
          lx_state = cdl_pkg::ST_LINE;
          lx_plen  = '0;
        end else begin
          lex_flush_restart(cdl_pkg::TK_DIV, c);
        end
      end
      cdl_pkg::ST_BLOCK: begin
        if (c == "*") lx_state = cdl_pkg::ST_BLOCK_STAR;
      end
      // a further star keeps us here, so a run of stars still closes
      cdl_pkg::ST_BLOCK_STAR: begin
        if (c == "/") lx_state = cdl_pkg::ST_START;
        else if (c != "*") lx_state = cdl_pkg::ST_BLOCK;
      end
      cdl_pkg::ST_LINE: begin
        if (c == "\n") lx_state = cdl_pkg::ST_START;
      end
      cdl_pkg::ST_EQ:   lex_relop(c, cdl_pkg::TK_ASSIGN, cdl_pkg::TK_EQ);
      cdl_pkg::ST_LT:   lex_relop(c, cdl_pkg::TK_LT, cdl_pkg::TK_LE);
      cdl_pkg::ST_GT:   lex_relop(c, cdl_pkg::TK_GT, cdl_pkg::TK_GE);
      cdl_pkg::ST_BANG: lex_relop(c, cdl_pkg::TK_NOT, cdl_pkg::TK_NE);
      default:          lex_from_start(c);
    endcase
    lx_pos++;
  endfunction

  // End of input: flush a pending token, drop an open comment, rewind
  function automatic void lex_end();
    if (!lx_halted) begin
      case (lx_state)
        cdl_pkg::ST_IDENT: lex_emit(cdl_pkg::TK_IDENT, lx_pstart, lx_plen);
        cdl_pkg::ST_NUM:   lex_emit(cdl_pkg::TK_NUM, lx_pstart, lx_plen);
        cdl_pkg::ST_SLASH: lex_emit(cdl_pkg::TK_DIV, lx_pstart, 16'd1);
        cdl_pkg::ST_EQ:    lex_emit(cdl_pkg::TK_ASSIGN, lx_pstart, 16'd1);
        cdl_pkg::ST_LT:    lex_emit(cdl_pkg::TK_LT, lx_pstart, 16'd1);
        cdl_pkg::ST_GT:    lex_emit(cdl_pkg::TK_GT, lx_pstart, 16'd1);
        cdl_pkg::ST_BANG:  lex_emit(cdl_pkg::TK_NOT, lx_pstart, 16'd1);
        default:           ;
      endcase
    end
    lex_emit(cdl_pkg::TK_EOF, lx_pos, 16'd0);
    lx_state  = cdl_pkg::ST_START;
    lx_pos    = '0;
    lx_pstart = '0;
    lx_plen   = '0;
    lx_halted = 1'b0;
  endfunction

  function automatic void lex_predict(logic eoi, logic [7:0] c);
    token_rec_t t;
    step_toks.delete();
    if (eoi) lex_end();
    else if (!lx_halted) lex_char(c);
    if (step_toks.size() != 0) begin
      t = step_toks.pop_back();
      t.last = 1'b1;
      step_toks.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] c);
    feed_q.push_back('{1'b0, c, PREDICT, NO_TOK, NO_TOK});
  endfunction

  // char_code is don't-care on end of input, so fill it with noise
  function automatic void add_end();
    feed_q.push_back('{1'b1, 8'($urandom_range(0, 255)), PREDICT, NO_TOK, NO_TOK});
  endfunction

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_alnum();
    if ($urandom_range(0, 2) == 0) return pick_from("0123456789");
    return pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz");
  endfunction

  // Append one lexeme with random content; return the count of bytes the lexer acts on
  function automatic int add_lexeme();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    n    = 0;
    if (pick < 25) begin
      add_byte(pick_from("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz"));
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) add_byte(pick_alnum());
      n++;
    end else if (pick < 40) begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) add_byte(pick_from("0123456789"));
    end else if (pick < 58) begin
      add_byte(pick_from("+-*,;{}()"));
      n = 1;
    end else if (pick < 70) begin
      add_byte(pick_from("=<>!"));
      n = 1;
      if ($urandom_range(0, 1) == 1) begin
        add_byte("=");
        n++;
      end
    end else if (pick < 74) begin
      add_byte("/");
      n = 1;
    end else if (pick < 80) begin
      add_byte("/");
      add_byte("*");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
      n += 2;
      if ($urandom_range(0, 3) == 0) begin
        add_end();      // leave the comment open
      end else begin
        for (int i = $urandom_range(1, 3); i > 0; i--) begin
          add_byte("*");
          n++;
        end
        add_byte("/");
        n++;
      end
    end else if (pick < 84) begin
      add_byte("/");
      add_byte("/");
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
      add_byte("\n");
      n += 3;
    end else if (pick < 94) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_byte(pick_from(" \t\n"));
    end else if (pick < 97) begin
      // invalid byte: the lexer halts, so the trailing noise is ignored
      do c = 8'($urandom_range(0, 255)); while (is_valid(c));
      add_byte(c);
      for (int i = $urandom_range(0, 3); i > 0; i--) add_byte(8'($urandom_range(0, 255)));
      add_end();
      n = 1;
    end else begin
      add_byte(8'($urandom_range(0, 255)));
      n = 1;
    end
    if ($urandom_range(0, 29) == 0) add_end();
    return n;
  endfunction

  function automatic void report_bad(string what, token_rec_t want, token_rec_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t token %s: expected kind %0d start %0d len %0d last %0d, got kind %0d",
               $realtime, what, want.kind, want.start, want.len, want.last, got.kind,
               " start %0d len %0d last %0d", got.start, got.len, got.last);
  endfunction

  // --------------------------------------------------------------------------
  // Output checker and input predictor, both on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    token_rec_t got;
    token_rec_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tdata[36:21], m_axis_tlast};
        if (tokens_due.size() == 0) begin
          report_bad("with none due", NO_TOK, got);
        end else begin
          want = tokens_due.pop_front();
          if (got.kind != want.kind || got.start != want.start ||
              got.len != want.len || got.last != want.last)
            report_bad("differs", want, got);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lex_predict(s_axis_tuser[0], s_axis_tdata);
        if (offered.n_given == PREDICT) begin
          foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
        end else begin
          if (offered.n_given >= 1) tokens_due.push_back(offered.given0);
          if (offered.n_given >= 2) tokens_due.push_back(offered.given1);
        end
      end
      item_taken <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Sender: bursts of random length, random gaps, drive on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || item_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (feed_q.size() != 0) begin
        offered = feed_q.pop_front();
        s_axis_tdata  <= offered.ch;
        s_axis_tuser  <= offered.eoi;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus two long hold-offs that let
  // the block fill up and push back on the sender
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 2800) hold_left = HOLD_CYCLES;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 512);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (rx_cycle % 5 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : run
    int made;
    made = 0;
    foreach (dir_table[i]) feed_q.push_back(dir_table[i]);
    while (made < RANDOM_ITEMS) made += add_lexeme();
    add_end();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (feed_q.size() != 0 || s_axis_tvalid);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cdl_pkg.sv
rtl/cdl_front.sv
rtl/cdl_queue.sv
rtl/cdl_back.sv
rtl/char_class_dfa_lexer.sv
tb/char_class_dfa_lexer_test.sv
